FILE: src/swmf_pkg.sv
package swmf_pkg;

	// Sizing of the line store and the window
	localparam int MAX_RADIUS = 7;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int RING_ROWS  = 2 * MAX_RADIUS + 2;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int SLOT_W     = $clog2(RING_ROWS);
	localparam int ADDR_W     = SLOT_W + COL_W;
	localparam int STORE_SIZE = RING_ROWS * MAX_WIDTH;

	// Field widths
	localparam int PIX_W      = 8;
	localparam int RAD_W      = 3;
	localparam int DIM_W      = 11;
	localparam int POS_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [RAD_W-1:0] RADIUS_RST = 3'd1;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

	// Input item modes
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

endpackage

FILE: src/swmf_in_if.sv
interface swmf_in_if;
	logic                       valid;
	logic                       ready;
	logic                       mode;
	logic [swmf_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output mode, output pixel_in, input ready);
	modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

FILE: src/swmf_out_if.sv
interface swmf_out_if;
	logic                       valid;
	logic                       ready;
	logic [swmf_pkg::PIX_W-1:0] median_out;
	logic                       frame_end;

	modport source (output valid, output median_out, output frame_end, input ready);
	modport sink (input valid, input median_out, input frame_end, output ready);
endinterface

FILE: src/swmf_cfg_if.sv
interface swmf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [swmf_pkg::CFG_IDX_W-1:0]  index;
	logic [swmf_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/swmf_ram.sv
module swmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: src/square_window_median_filter_core.sv
// Each accepted item passes ST_RDY1 and ST_RDY2; if the window of the current output center
// is complete, nine window scans through the one store read port (ST_SCAN, ST_SDONE)
// follow, then ST_FIN, which waits while the result side stalls. A new item is taken
// only in ST_IDLE, so the core takes no item until it is through with the last one.
// Reset: arst_n clears positions, control and registers to their defaults;
// the line store is not cleared and needs no clearing pass.
module square_window_median_filter_core (
	input logic       clk,
	input logic       arst_n,
	swmf_cfg_if.sink  cfg,
	swmf_in_if.sink   pix,
	swmf_out_if.source res
);
	import swmf_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RDY1  = 3'd1;
	localparam logic [2:0] ST_RDY2  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_SDONE = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0]        state_q;
	logic [RAD_W-1:0]  radius_q;
	logic [DIM_W-1:0]  fwidth_q, fheight_q;
	logic [POS_W-1:0]  in_row_q, in_col_q, out_row_q, out_col_q;
	logic [SLOT_W-1:0] in_slot_q, out_slot_q;
	logic              in_ahead_q;
	logic [22:0]       got_q;
	logic [3:0]        i_q, j_q, pass_q;
	logic [7:0]        cnt_lo_q, cnt_hi_q, n_q;
	logic [PIX_W-1:0]  ans_lo_q, ans_hi_q;
	logic              mark_s1;
	logic              res_valid_q, res_fe_q;
	logic [PIX_W-1:0]  res_med_q;

	logic [RAD_W-1:0]  r_eff;
	logic [DIM_W-1:0]  w_eff, h_eff;
	logic              pix_acc, out_free;
	logic [PIX_W-1:0]  rd_data;
	logic [ADDR_W-1:0] rd_addr;

	// Saturated register values
	always_comb begin
		r_eff = (radius_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_q;
		if (fwidth_q == '0) w_eff = DIM_W'(1);
		else if (fwidth_q > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
		else w_eff = fwidth_q;
		if (fheight_q == '0) h_eff = DIM_W'(1);
		else if (fheight_q > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
		else h_eff = fheight_q;
	end

	assign pix.ready = (state_q == ST_IDLE);
	assign pix_acc   = pix.valid && pix.ready;
	assign cfg.ready = 1'b1;
	assign out_free  = !res_valid_q || res.ready;

	assign res.valid      = res_valid_q;
	assign res.median_out = res_med_q;
	assign res.frame_end  = res_fe_q;

	// Readiness check: raster index of the input against the window's last sample
	logic [20:0]      got_prod;
	logic [DIM_W-1:0] ny_sum, nx_sum, ny, nx;
	logic [21:0]      need_prod;
	logic [22:0]      need;
	always_comb begin
		got_prod  = in_row_q * w_eff;
		ny_sum    = {1'b0, out_row_q} + DIM_W'(r_eff);
		nx_sum    = {1'b0, out_col_q} + DIM_W'(r_eff);
		ny        = (ny_sum > h_eff - 1'b1) ? h_eff - 1'b1 : ny_sum;
		nx        = (nx_sum > w_eff - 1'b1) ? w_eff - 1'b1 : nx_sum;
		need_prod = ny * w_eff;
		need      = {1'b0, need_prod} + {12'b0, nx};
	end

	// Window position of the current scan step
	logic [11:0]       yv, xv;
	logic [SLOT_W-1:0] slot_sel;
	logic              win_ok, scan_last;
	logic [3:0]        side_m1;
	always_comb begin
		side_m1   = {r_eff, 1'b0};
		yv        = {2'b0, out_row_q} - 12'(r_eff) + 12'(i_q);
		xv        = {2'b0, out_col_q} - 12'(r_eff) + 12'(j_q);
		slot_sel  = out_slot_q - SLOT_W'(r_eff) + SLOT_W'(i_q);
		win_ok    = !yv[11] && (yv[10:0] < h_eff) && !xv[11] && (xv[10:0] < w_eff);
		rd_addr   = {slot_sel, xv[COL_W-1:0]};
		scan_last = (i_q == side_m1) && (j_q == side_m1);
	end

	// Shared compare unit: counts samples below the two rank candidates; pass 0 counts every window sample
	logic [2:0]       bidx;
	logic [PIX_W-1:0] cand_lo, cand_hi;
	logic [7:0]       cnt_lo_d, cnt_hi_d, lo_rank, hi_rank;
	logic             hit_lo, hit_hi;
	always_comb begin
		bidx     = 3'(4'd8 - pass_q);
		cand_lo  = ans_lo_q | (PIX_W'(1) << bidx);
		cand_hi  = ans_hi_q | (PIX_W'(1) << bidx);
		hit_lo   = mark_s1 && ((pass_q == '0) || (rd_data < cand_lo));
		hit_hi   = mark_s1 && (pass_q != '0) && (rd_data < cand_hi);
		cnt_lo_d = cnt_lo_q + 8'(hit_lo);
		cnt_hi_d = cnt_hi_q + 8'(hit_hi);
		lo_rank  = (n_q - 8'd1) >> 1;
		hi_rank  = n_q >> 1;
	end

	logic [8:0] med_sum;
	assign med_sum = {1'b0, ans_lo_q} + {1'b0, ans_hi_q};

	swmf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_SIZE)
	) u_store (
		.clk  (clk),
		.we   (pix_acc && (pix.mode == MODE_PIXEL)),
		.waddr({in_slot_q, in_col_q}),
		.wdata(pix.pixel_in),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RADIUS_RST;
			fwidth_q  <= WIDTH_RST;
			fheight_q <= HEIGHT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_RADIUS: radius_q  <= cfg.data[RAD_W-1:0];
				REG_WIDTH:  fwidth_q  <= cfg.data;
				REG_HEIGHT: fheight_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_row_q    <= '0;
			in_col_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			in_slot_q   <= '0;
			out_slot_q  <= '0;
			in_ahead_q  <= 1'b0;
			got_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			pass_q      <= '0;
			cnt_lo_q    <= '0;
			cnt_hi_q    <= '0;
			n_q         <= '0;
			ans_lo_q    <= '0;
			ans_hi_q    <= '0;
			mark_s1     <= 1'b0;
			res_valid_q <= 1'b0;
			res_fe_q    <= 1'b0;
			res_med_q   <= '0;
		end else begin
			mark_s1 <= (state_q == ST_SCAN) && win_ok;
			// result leaves; a new one is only loaded in ST_FIN
			if (res_valid_q && res.ready && (state_q != ST_FIN)) res_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						if (pix.mode == MODE_PIXEL) begin
							if ({1'b0, in_col_q} + 1'b1 >= w_eff) begin
								in_col_q  <= '0;
								in_slot_q <= in_slot_q + 1'b1;
								if ({1'b0, in_row_q} + 1'b1 >= h_eff) begin
									in_row_q   <= '0;
									in_ahead_q <= 1'b1;
								end else begin
									in_row_q <= in_row_q + 1'b1;
								end
							end else begin
								in_col_q <= in_col_q + 1'b1;
							end
						end
						state_q <= ST_RDY1;
					end
				end
				ST_RDY1: begin
					got_q   <= {2'b0, got_prod} + {13'b0, in_col_q};
					state_q <= ST_RDY2;
				end
				ST_RDY2: begin
					if (in_ahead_q || (got_q > need)) begin
						i_q      <= '0;
						j_q      <= '0;
						pass_q   <= '0;
						cnt_lo_q <= '0;
						cnt_hi_q <= '0;
						ans_lo_q <= '0;
						ans_hi_q <= '0;
						state_q  <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					cnt_lo_q <= cnt_lo_d;
					cnt_hi_q <= cnt_hi_d;
					if (scan_last) begin
						state_q <= ST_SDONE;
					end else if (j_q == side_m1) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_SDONE: begin
					// close the pass on the final counts
					if (pass_q == '0) begin
						n_q <= cnt_lo_d;
					end else begin
						if (cnt_lo_d <= lo_rank) ans_lo_q <= cand_lo;
						if (cnt_hi_d <= hi_rank) ans_hi_q <= cand_hi;
					end
					cnt_lo_q <= '0;
					cnt_hi_q <= '0;
					i_q      <= '0;
					j_q      <= '0;
					if (pass_q == 4'd8) begin
						state_q <= ST_FIN;
					end else begin
						pass_q  <= pass_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_med_q   <= (n_q == '0) ? '0 : med_sum[8:1];
						res_fe_q    <= 1'b0;
						if ({1'b0, out_col_q} + 1'b1 >= w_eff) begin
							out_col_q  <= '0;
							out_slot_q <= out_slot_q + 1'b1;
							if ({1'b0, out_row_q} + 1'b1 >= h_eff) begin
								out_row_q  <= '0;
								res_fe_q   <= 1'b1;
								in_ahead_q <= 1'b0;
							end else begin
								out_row_q <= out_row_q + 1'b1;
							end
						end else begin
							out_col_q <= out_col_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
